// ===== rtl/core/hcl_pkg.sv =====
`default_nettype none

package hcl_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned StepW      = 4;

  localparam logic [2:0] LineLen   = 3'd7;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharBs    = 8'h08;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharDel   = 8'h7F;
  localparam logic [7:0] CharHash  = 8'h23;

  // What the back end has to produce for one received byte.
  typedef enum logic [2:0] {
    KindEcho,
    KindBlink,
    KindErase,
    KindColor,
    KindError
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cmd_t;

  function automatic logic is_hex(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic [3:0] nibble(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    case (c) inside
      [8'h30:8'h39]: t = c - 8'h30;
      [8'h41:8'h46]: t = c - 8'h37;
      [8'h61:8'h66]: t = c - 8'h57;
      default:       t = 8'h00;
    endcase
    return t[3:0];
  endfunction

  function automatic logic [7:0] err_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h45;
      3'd1:    c = 8'h52;
      3'd2:    c = 8'h52;
      3'd3:    c = 8'h4F;
      3'd4:    c = 8'h52;
      3'd5:    c = CharCr;
      3'd6:    c = CharLf;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Index of the final result for each command kind.
  function automatic logic [StepW-1:0] last_step(input kind_e kind);
    logic [StepW-1:0] s;
    case (kind)
      KindEcho:  s = StepW'(0);
      KindBlink: s = StepW'(0);
      KindErase: s = StepW'(2);
      KindColor: s = StepW'(2);
      KindError: s = StepW'(8);
      default:   s = StepW'(0);
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hcl_front.sv =====
`default_nettype none

// Holds the line buffer, classifies each received byte and issues one command.
module hcl_front (
  input  var logic         clk_i,
  input  var logic         rst_ni,
  input  var logic         in_valid_i,
  output var logic         in_stall_o,
  input  var logic [7:0]   rx_byte_i,
  input  var logic         q_full_i,
  output var logic         q_push_o,
  output var hcl_pkg::cmd_t q_cmd_o
);

  logic [7:0] line_q [7];
  logic [2:0] fill_q;
  logic [2:0] fill_d;

  logic accept;
  logic is_cr;
  logic del_ok;
  logic app_ok;
  logic line_ok;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  assign is_cr  = (rx_byte_i == hcl_pkg::CharCr);
  assign del_ok = (rx_byte_i == hcl_pkg::CharDel) && (fill_q != 3'd0);
  assign app_ok = (fill_q < hcl_pkg::LineLen) &&
                  (hcl_pkg::is_hex(rx_byte_i) || (rx_byte_i == hcl_pkg::CharHash));

  always_comb begin
    line_ok = (fill_q == hcl_pkg::LineLen) && (line_q[0] == hcl_pkg::CharHash);
    for (int i = 1; i < 7; i++) begin
      if (line_q[i] == hcl_pkg::CharHash) begin
        line_ok = 1'b0;
      end
    end
  end

  always_comb begin
    q_cmd_o.ch    = rx_byte_i;
    q_cmd_o.red   = {hcl_pkg::nibble(line_q[1]), hcl_pkg::nibble(line_q[2])};
    q_cmd_o.green = {hcl_pkg::nibble(line_q[3]), hcl_pkg::nibble(line_q[4])};
    q_cmd_o.blue  = {hcl_pkg::nibble(line_q[5]), hcl_pkg::nibble(line_q[6])};
    fill_d        = fill_q;
    if (is_cr) begin
      q_cmd_o.kind = line_ok ? hcl_pkg::KindColor : hcl_pkg::KindError;
      fill_d       = 3'd0;
    end else if (del_ok) begin
      q_cmd_o.kind = hcl_pkg::KindErase;
      fill_d       = fill_q - 3'd1;
    end else if (app_ok) begin
      q_cmd_o.kind = hcl_pkg::KindEcho;
      fill_d       = fill_q + 3'd1;
    end else begin
      q_cmd_o.kind = hcl_pkg::KindBlink;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 3'd0;
    end else if (accept) begin
      fill_q <= fill_d;
    end
  end

  // Characters past the fill count never affect a result, so the buffer needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept && !is_cr && !del_ok && app_ok) begin
      line_q[fill_q] <= rx_byte_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hcl_fifo.sv =====
`default_nettype none

// Short command queue between the front and back ends.
module hcl_fifo #(
  parameter int unsigned Depth = hcl_pkg::QueueDepth
) (
  input  var logic          clk_i,
  input  var logic          rst_ni,
  input  var logic          push_i,
  input  var hcl_pkg::cmd_t push_cmd_i,
  output var logic          full_o,
  input  var logic          pop_i,
  output var logic          valid_o,
  output var hcl_pkg::cmd_t pop_cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hcl_pkg::cmd_t    mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q;
  logic [PtrW-1:0]  rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o    = (count_q == CntW'(Depth));
  assign valid_o   = (count_q != '0);
  assign pop_cmd_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hcl_back.sv =====
`default_nettype none

// Expands one command into its sequence of result transfers.
module hcl_back (
  input  var logic          clk_i,
  input  var logic          rst_ni,
  input  var logic          q_valid_i,
  input  var hcl_pkg::cmd_t q_cmd_i,
  output var logic          q_pop_o,
  output var logic          out_valid_o,
  input  var logic          out_stall_i,
  output var logic          tx_valid_o,
  output var logic [7:0]    tx_char_o,
  output var logic          error_blink_o,
  output var logic          color_valid_o,
  output var logic [7:0]    red_o,
  output var logic [7:0]    green_o,
  output var logic [7:0]    blue_o,
  output var logic          last_o
);

  hcl_pkg::cmd_t              cmd_q;
  logic [hcl_pkg::StepW-1:0]  step_q;
  logic [2:0]                 err_idx;
  logic                       busy_q;
  logic                       out_accept;

  assign out_valid_o = busy_q;
  assign out_accept  = busy_q && !out_stall_i;
  assign last_o      = (step_q == hcl_pkg::last_step(cmd_q.kind));
  assign q_pop_o     = q_valid_i && (!busy_q || (out_accept && last_o));
  assign err_idx     = step_q[2:0] - 3'd2;

  always_comb begin
    tx_valid_o    = 1'b0;
    tx_char_o     = 8'h00;
    error_blink_o = 1'b0;
    color_valid_o = 1'b0;
    red_o         = 8'h00;
    green_o       = 8'h00;
    blue_o        = 8'h00;
    case (cmd_q.kind)
      hcl_pkg::KindEcho: begin
        tx_valid_o = 1'b1;
        tx_char_o  = cmd_q.ch;
      end
      hcl_pkg::KindBlink: begin
        error_blink_o = 1'b1;
      end
      hcl_pkg::KindErase: begin
        tx_valid_o = 1'b1;
        tx_char_o  = (step_q == hcl_pkg::StepW'(1)) ? hcl_pkg::CharSpace : hcl_pkg::CharBs;
      end
      hcl_pkg::KindColor: begin
        if (step_q == hcl_pkg::StepW'(0)) begin
          tx_valid_o = 1'b1;
          tx_char_o  = hcl_pkg::CharCr;
        end else if (step_q == hcl_pkg::StepW'(1)) begin
          tx_valid_o = 1'b1;
          tx_char_o  = hcl_pkg::CharLf;
        end else begin
          color_valid_o = 1'b1;
          red_o         = cmd_q.red;
          green_o       = cmd_q.green;
          blue_o        = cmd_q.blue;
        end
      end
      hcl_pkg::KindError: begin
        tx_valid_o = 1'b1;
        if (step_q == hcl_pkg::StepW'(0)) begin
          tx_char_o = hcl_pkg::CharCr;
        end else if (step_q == hcl_pkg::StepW'(1)) begin
          tx_char_o = hcl_pkg::CharLf;
        end else begin
          tx_char_o = hcl_pkg::err_char(err_idx);
        end
      end
      default: begin
        tx_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (q_pop_o) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (out_accept) begin
      if (last_o) begin
        busy_q <= 1'b0;
      end else begin
        step_q <= step_q + hcl_pkg::StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hex_color_line_parser.sv =====
// Each byte's command is written into the queue and then loaded into the back end's
// command register, from which its first result is offered.
// Throughput: the front end takes one byte per cycle while the command queue has room;
// the back end issues one result per cycle while out_stall_i is low, 1 to 9 per byte
// (9 for a rejected line), so the sustained rate is set by the back end's result sequencer.
// Reset: asynchronous, active low; clears the fill count, the queue and the sequencer.
`default_nettype none

module hex_color_line_parser #(
  parameter int unsigned QueueDepth = hcl_pkg::QueueDepth
) (
  input  var logic       clk_i,
  input  var logic       rst_ni,
  input  var logic       in_valid_i,
  output var logic       in_stall_o,
  input  var logic [7:0] rx_byte_i,
  output var logic       out_valid_o,
  input  var logic       out_stall_i,
  output var logic       tx_valid_o,
  output var logic [7:0] tx_char_o,
  output var logic       error_blink_o,
  output var logic       color_valid_o,
  output var logic [7:0] red_o,
  output var logic [7:0] green_o,
  output var logic [7:0] blue_o,
  output var logic       last_o
);

  // The front end classifies every byte and updates the line at once, so the
  // next byte can be taken in the following cycle if the queue is not full.
  // Each byte becomes one command in the queue. The line buffer is not reset.
  logic          push;
  logic          full;
  logic          pop;
  logic          q_valid;
  hcl_pkg::cmd_t push_cmd;
  hcl_pkg::cmd_t pop_cmd;

  hcl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_cmd_o    (push_cmd)
  );

  // The queue lets the front keep taking bytes while the back end stalls, until it fills.
  hcl_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (pop_cmd)
  );

  // The back end turns each command into its echo, erase, message, blink or color results,
  // loading the next command in the same cycle as the last transfer.
  hcl_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_cmd_i       (pop_cmd),
    .q_pop_o       (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .tx_valid_o    (tx_valid_o),
    .tx_char_o     (tx_char_o),
    .error_blink_o (error_blink_o),
    .color_valid_o (color_valid_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/hcl_checker.sv =====
`default_nettype none

module hcl_props (
  input var logic       clk_i,
  input var logic       rst_ni,
  input var logic       out_valid_i,
  input var logic       out_stall_i,
  input var logic       tx_valid_i,
  input var logic [7:0] tx_char_i,
  input var logic       error_blink_i,
  input var logic       color_valid_i,
  input var logic       last_i
);

  // A stalled result keeps its transmit byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(tx_char_i) && $stable(tx_valid_i))
    else $error("stalled result changed");

  // A result carries exactly one kind of content.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $onehot({tx_valid_i, error_blink_i, color_valid_i}))
    else $error("result has no or several kinds of content");

  // An error blink or a color is always the final result for its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (error_blink_i || color_valid_i) |-> last_i)
    else $error("blink or color result not marked last");

  // A CR that is not the final result of its byte is followed at once by LF.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_stall_i && tx_valid_i && tx_char_i == hcl_pkg::CharCr && !last_i
    |=> out_valid_i && tx_valid_i && tx_char_i == hcl_pkg::CharLf)
    else $error("CR not followed by LF");

endmodule

bind hex_color_line_parser hcl_props u_hcl_props (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .tx_valid_i    (tx_valid_o),
  .tx_char_i     (tx_char_o),
  .error_blink_i (error_blink_o),
  .color_valid_i (color_valid_o),
  .last_i        (last_o)
);

`default_nettype wire

// ===== sim/hcl_checker.sv =====
`timescale 1ns / 1ps

module hcl_checker (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        in_valid_i,
  input  var logic        in_stall_i,
  input  var logic [7:0]  rx_byte_i,
  input  var logic        out_valid_i,
  input  var logic        out_stall_i,
  input  var logic        tx_valid_i,
  input  var logic [7:0]  tx_char_i,
  input  var logic        error_blink_i,
  input  var logic        color_valid_i,
  input  var logic [7:0]  red_i,
  input  var logic [7:0]  green_i,
  input  var logic [7:0]  blue_i,
  input  var logic        last_i,
  output int unsigned     pending_o,
  output int unsigned     fails_o
);

  import hcl_pkg::*;

  localparam logic [39:0] ErrorWord = "ERROR";

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_char;
    logic       error_blink;
    logic       color_valid;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } tx_rec_t;

  tx_rec_t     echo_q[$];
  tx_rec_t     want_r;
  logic [7:0]  line_q [7];
  int unsigned fill_cnt = 0;
  int unsigned err_cnt  = 0;

  assign fails_o = err_cnt;

  task automatic report_mismatch(input string what);
    if (err_cnt < 40) begin
      $display("%0t ns: mismatch, %s", $time, what);
    end
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %02h want %02h", name, got, want));
    end
  endtask

  function automatic logic is_hex_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (c <= "9") begin
      v = c - "0";
    end else if (c <= "F") begin
      v = c - "A" + 8'd10;
    end else begin
      v = c - "a" + 8'd10;
    end
    return v[3:0];
  endfunction

  function automatic tx_rec_t char_rec(input logic [7:0] c);
    tx_rec_t r;
    r = '0;
    r.tx_valid = 1'b1;
    r.tx_char  = c;
    return r;
  endfunction

  // Works out every result caused by one received byte and updates the line.
  task automatic predict_byte(input logic [7:0] b);
    tx_rec_t fresh[$];
    tx_rec_t r;
    logic    good;
    if (b == CharCr) begin
      fresh.push_back(char_rec(CharCr));
      fresh.push_back(char_rec(CharLf));
      good = (fill_cnt == LineLen) && (line_q[0] == CharHash);
      for (int i = 1; i < 7; i++) begin
        if (line_q[i] == CharHash) good = 1'b0;
      end
      if (good) begin
        r = '0;
        r.color_valid = 1'b1;
        r.red   = {digit_value(line_q[1]), digit_value(line_q[2])};
        r.green = {digit_value(line_q[3]), digit_value(line_q[4])};
        r.blue  = {digit_value(line_q[5]), digit_value(line_q[6])};
        fresh.push_back(r);
      end else begin
        for (int i = 0; i < 5; i++) begin
          fresh.push_back(char_rec(ErrorWord[39-8*i -: 8]));
        end
        fresh.push_back(char_rec(CharCr));
        fresh.push_back(char_rec(CharLf));
      end
      fill_cnt = 0;
    end else if (b == CharDel && fill_cnt != 0) begin
      fill_cnt--;
      fresh.push_back(char_rec(CharBs));
      fresh.push_back(char_rec(CharSpace));
      fresh.push_back(char_rec(CharBs));
    end else if (fill_cnt < LineLen && (is_hex_char(b) || b == CharHash)) begin
      line_q[fill_cnt] = b;
      fill_cnt++;
      fresh.push_back(char_rec(b));
    end else begin
      r = '0;
      r.error_blink = 1'b1;
      fresh.push_back(r);
    end
    foreach (fresh[i]) begin
      r = fresh[i];
      r.last = (i == fresh.size() - 1);
      echo_q.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_q.delete();
      fill_cnt = 0;
      foreach (line_q[i]) line_q[i] = '0;
      pending_o <= 0;
    end else begin
      // Results go first: none can stem from a byte taken at this same edge.
      if (out_valid_i && !out_stall_i) begin
        if (echo_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, tx_char %02h", tx_char_i));
        end else begin
          want_r = echo_q.pop_front();
          check_field("tx_valid", 8'(tx_valid_i), 8'(want_r.tx_valid));
          check_field("tx_char", tx_char_i, want_r.tx_char);
          check_field("error_blink", 8'(error_blink_i), 8'(want_r.error_blink));
          check_field("color_valid", 8'(color_valid_i), 8'(want_r.color_valid));
          check_field("red", red_i, want_r.red);
          check_field("green", green_i, want_r.green);
          check_field("blue", blue_i, want_r.blue);
          check_field("last", 8'(last_i), 8'(want_r.last));
        end
      end
      if (in_valid_i && !in_stall_i) predict_byte(rx_byte_i);
      pending_o <= echo_q.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

  import hcl_pkg::*;

  // Clock and reset. Every block input has a known value from time zero.
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_stall_i = 1'b0;

  logic       in_stall_o;
  logic       out_valid_o;
  logic       tx_valid_o;
  logic [7:0] tx_char_o;
  logic       error_blink_o;
  logic       color_valid_o;
  logic [7:0] red_o;
  logic [7:0] green_o;
  logic [7:0] blue_o;
  logic       last_o;

  int unsigned pending;
  int unsigned fails;

  // Sender bookkeeping: bytes transferred so far and what is left of the burst.
  int unsigned sent_cnt   = 0;
  int unsigned burst_left = 1;

  // Receiver bookkeeping: its own cycle count and the long hold-off.
  int unsigned rx_cycle  = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  hex_color_line_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .tx_valid_o    (tx_valid_o),
    .tx_char_o     (tx_char_o),
    .error_blink_o (error_blink_o),
    .color_valid_o (color_valid_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .last_o        (last_o)
  );

  // The checker watches both channels, keeps its own copy of the line and
  // hands back how many results are still owed and how many checks failed.
  hcl_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .tx_valid_i    (tx_valid_o),
    .tx_char_i     (tx_char_o),
    .error_blink_i (error_blink_o),
    .color_valid_i (color_valid_o),
    .red_i         (red_o),
    .green_i       (green_o),
    .blue_i        (blue_o),
    .last_i        (last_o),
    .pending_o     (pending),
    .fails_o       (fails)
  );

  // Offers one byte and waits for its transfer. At the end of a burst the
  // sender may go quiet for a random gap; a zero gap chains bursts together,
  // which gives long stretches without any idling on the input side.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    sent_cnt++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  // A random hex digit, upper or lower case.
  function automatic logic [7:0] rand_hex();
    logic [7:0] k;
    k = 8'($urandom_range(0, 21));
    if (k < 10) return "0" + k;
    if (k < 16) return "A" + k - 8'd10;
    return "a" + k - 8'd16;
  endfunction

  // One random line. Half of them are well-formed color lines with random
  // digits, since only those reach the color path; the rest are short or
  // long lines, lines with a stray hash, runs of deletes that empty the
  // line and then keep going, and plain noise over the whole byte range.
  task automatic send_random_line();
    int unsigned kind;
    int unsigned len;
    int unsigned pos;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3, 4: begin
        send_byte(CharHash);
        for (int i = 0; i < 6; i++) begin
          // Now and then a typo that is deleted straight away.
          if ($urandom_range(0, 7) == 0) begin
            send_byte(rand_hex());
            send_byte(CharDel);
          end
          send_byte(rand_hex());
        end
        // A character past the seventh is rejected and leaves the line alone.
        if ($urandom_range(0, 5) == 0) send_byte(rand_hex());
        send_byte(CharCr);
      end
      5, 6: begin
        len = $urandom_range(0, 8);
        for (int i = 0; i < len; i++) begin
          send_byte(($urandom_range(0, 5) == 0) ? CharHash : rand_hex());
          if ($urandom_range(0, 9) == 0) send_byte(CharDel);
        end
        send_byte(CharCr);
      end
      7: begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
      end
      8: begin
        // Seven characters led by a hash, with a second hash somewhere.
        send_byte(CharHash);
        pos = $urandom_range(1, 6);
        for (int i = 1; i < 7; i++) send_byte((i == pos) ? CharHash : rand_hex());
        send_byte(CharCr);
      end
      default: begin
        len = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) send_byte(rand_hex());
        for (int i = 0; i < len + $urandom_range(1, 2); i++) send_byte(CharDel);
        send_byte(CharCr);
      end
    endcase
  endtask

  // Receiver: one long hold-off once the sender is well under way, so that
  // the block fills up and has to stall its input, and otherwise a pattern
  // that moves in turn between no stalls, light and heavy random
  // stalls, and a fixed rhythm.
  always @(posedge clk_i) begin
    rx_cycle++;
    if (!hold_done && sent_cnt >= 120) begin
      hold_left = 300;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case ((rx_cycle / 97) % 4)
        0: begin
          out_stall_i <= 1'b0;
        end
        1: begin
          out_stall_i <= ($urandom_range(0, 3) == 0);
        end
        2: begin
          out_stall_i <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_stall_i <= ((rx_cycle % 5) < 2);
        end
      endcase
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A delete and a carriage return on an empty line.
    send_byte(CharDel);
    send_byte(CharCr);
    // A full line in mixed case, an eighth character that bounces off the
    // full line, then the end of line that yields the color.
    send_text("#0aF9fA1");
    send_byte(CharCr);
    // A delete on a line that holds something, then the line completed to a valid one.
    send_text("#F");
    send_byte(CharDel);
    send_text("f0b7Ce");
    send_byte(CharCr);
    // Bytes next to the digit and letter ranges, and both ends of the byte range.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("G/`:");
    // A short line that does not start with a hash.
    send_text("12#");
    send_byte(CharCr);

    // Random part.
    while (sent_cnt < 410) send_random_line();
    in_valid_i <= 1'b0;

    // Drain: wait for every owed result, then keep watching for strays.
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/hcl_pkg.sv
rtl/core/hcl_front.sv
rtl/core/hcl_fifo.sv
rtl/core/hcl_back.sv
rtl/core/hex_color_line_parser.sv
rtl/core/hcl_checker.sv
sim/hcl_checker.sv
sim/tb.sv
